@@ src/msbt_pkg.sv @@
`default_nettype none

package msbt_pkg;

    // Store geometry.
    localparam int STORE_DEPTH = 64;
    localparam int ITEM_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // Fixed port widths.
    localparam int OP_W        = 2;
    localparam int IN_ITEM_W   = 32;
    localparam int OUT_CNT_W   = 7;

    // Operation codes carried by the input word.
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_COUNT  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_MOVE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ src/multiset_bag_table_top.sv @@
`default_nettype none

// Bag of items held in a single-port-write, single-port-read synchronous RAM.
// Add and clear go straight to the result; count scans every stored entry;
// remove scans from the newest entry down and moves the newest entry into the hole.
// One word is handled at a time; the RAM scan makes one compare per cycle.
// A new word is taken while the previous result still waits on the output.
// Synchronous active-low reset empties the bag; RAM contents are not cleared.
module multiset_bag_table_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [msbt_pkg::OP_W-1:0]          s_operation,
    input  wire logic [msbt_pkg::IN_ITEM_W-1:0]     s_item_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_success,
    output logic [msbt_pkg::OUT_CNT_W-1:0]          m_occurrences,
    output logic [msbt_pkg::OUT_CNT_W-1:0]          m_current_size,
    output logic                                    m_full_res
);
    import msbt_pkg::*;

    // Item storage with a registered read.
    logic [ITEM_WIDTH-1:0] mem [STORE_DEPTH];
    logic [ITEM_WIDTH-1:0] rd_data_reg;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ITEM_WIDTH-1:0] wr_data;

    // Control and working registers.
    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [ITEM_WIDTH-1:0] item_reg, item_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [CNT_W-1:0]      left_reg, left_next;
    logic                  pend_reg, pend_next;
    logic [ADDR_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0]     hit_reg, hit_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic                  succ_reg, succ_next;
    logic                  full_reg, full_next;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    logic                  m_success_reg, m_success_next;
    logic [CNT_W-1:0]      m_occ_reg, m_occ_next;
    logic [CNT_W-1:0]      m_size_reg, m_size_next;
    logic                  m_full_reg, m_full_next;

    logic                  accept;
    logic                  out_free;
    logic                  match;
    logic [CNT_W-1:0]      count_dec;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign match     = (rd_data_reg == item_reg);
    assign count_dec = count_reg - CNT_W'(1);

    // RAM write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (op_t'(s_operation) inside {OP_REMOVE, OP_COUNT}) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (pend_reg && match && op_reg == OP_REMOVE) begin
                    state_next = ST_FETCH;
                end else if (left_reg == '0 && !pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_FETCH: state_next = ST_MOVE;
            ST_MOVE:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and RAM control.
    always_comb begin
        op_next        = op_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        left_next      = left_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        hit_next       = hit_reg;
        occ_next       = occ_reg;
        succ_next      = succ_reg;
        full_next      = full_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_success_next = m_success_reg;
        m_occ_next     = m_occ_reg;
        m_size_next    = m_size_reg;
        m_full_next    = m_full_reg;
        rd_en          = 1'b0;
        rd_addr        = addr_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[ADDR_W-1:0];
        wr_data        = s_item_value[ITEM_WIDTH-1:0];
        s_ready        = (state_reg == ST_IDLE);

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next   = op_t'(s_operation);
                    item_next = s_item_value[ITEM_WIDTH-1:0];
                    occ_next  = '0;
                    succ_next = 1'b0;
                    full_next = 1'b0;
                    left_next = count_reg;
                    case (op_t'(s_operation))
                        OP_ADD: begin
                            if (count_reg < CNT_W'(STORE_DEPTH)) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                succ_next  = 1'b1;
                            end else begin
                                full_next  = 1'b1;
                            end
                        end
                        // Remove scans from the newest entry down.
                        OP_REMOVE: addr_next = count_dec[ADDR_W-1:0];
                        OP_COUNT:  addr_next = '0;
                        OP_CLEAR: begin
                            count_next = '0;
                            succ_next  = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // Issue the next read while comparing the previous one.
                if (left_reg != '0) begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = addr_reg;
                    left_next      = left_reg - CNT_W'(1);
                    if (op_reg == OP_REMOVE) begin
                        addr_next = addr_reg - ADDR_W'(1);
                    end else begin
                        addr_next = addr_reg + ADDR_W'(1);
                    end
                end
                if (pend_reg && match) begin
                    if (op_reg == OP_REMOVE) begin
                        hit_next  = pend_addr_reg;
                        succ_next = 1'b1;
                        pend_next = 1'b0;
                    end else begin
                        occ_next  = occ_reg + CNT_W'(1);
                        succ_next = 1'b1;
                    end
                end
            end
            ST_FETCH: begin
                // Read the newest entry to fill the hole.
                rd_en   = 1'b1;
                rd_addr = count_dec[ADDR_W-1:0];
            end
            ST_MOVE: begin
                wr_en      = 1'b1;
                wr_addr    = hit_reg;
                wr_data    = rd_data_reg;
                count_next = count_dec;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_success_next = succ_reg;
                    m_occ_next     = occ_reg;
                    m_size_next    = count_reg;
                    m_full_next    = full_reg;
                end
            end
            default: ;
        endcase
    end

    // Register update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg        <= op_next;
        item_reg      <= item_next;
        addr_reg      <= addr_next;
        left_reg      <= left_next;
        pend_addr_reg <= pend_addr_next;
        hit_reg       <= hit_next;
        occ_reg       <= occ_next;
        succ_reg      <= succ_next;
        full_reg      <= full_next;
        m_success_reg <= m_success_next;
        m_occ_reg     <= m_occ_next;
        m_size_reg    <= m_size_next;
        m_full_reg    <= m_full_next;
    end

    // Output ports.
    assign m_valid        = m_valid_reg;
    assign m_success      = m_success_reg;
    assign m_occurrences  = OUT_CNT_W'(m_occ_reg);
    assign m_current_size = OUT_CNT_W'(m_size_reg);
    assign m_full_res     = m_full_reg;

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import msbt_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_WORDS  = 500;
    localparam int IDLE_PERCENT  = 37;
    localparam int TAIL_CYCLES   = 100;
    localparam int POOL_SIZE     = 8;

    // One result word as the block reports it.
    typedef struct packed {
        logic                 success;
        logic [OUT_CNT_W-1:0] occurrences;
        logic [OUT_CNT_W-1:0] current_size;
        logic                 full_res;
    } bag_result_t;

    // One row of the directed stimulus; typed rows carry a hand-written result.
    typedef struct {
        op_t                  op;
        logic [IN_ITEM_W-1:0] value;
        bit                   typed;
        bag_result_t          result;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [OP_W-1:0]       s_operation;
    logic [IN_ITEM_W-1:0]  s_item_value;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_success;
    logic [OUT_CNT_W-1:0]  m_occurrences;
    logic [OUT_CNT_W-1:0]  m_current_size;
    logic                  m_full_res;

    // Shadow copy of the bag used to predict each result.
    logic [ITEM_WIDTH-1:0] bag_items [STORE_DEPTH];
    int                    bag_count;

    bag_result_t           expected_results [$];
    bit                    typed_flags [$];
    bag_result_t           typed_results [$];
    stim_row_t             stim_rows [$];
    logic [IN_ITEM_W-1:0]  value_pool [POOL_SIZE];

    int                    error_count;
    int                    cycle_count;
    bit                    quiet;

    multiset_bag_table_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_item_value   (s_item_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_success      (m_success),
        .m_occurrences  (m_occurrences),
        .m_current_size (m_current_size),
        .m_full_res     (m_full_res)
    );

    always #2 aclk = ~aclk;

    // Apply one operation to the shadow bag and return the result it yields.
    function automatic bag_result_t bag_apply(input op_t op, input logic [IN_ITEM_W-1:0] value);
        bag_result_t           res;
        logic [ITEM_WIDTH-1:0] item;
        int                    n;
        int                    k;
        int                    hits;
        bit                    found;
        res   = '0;
        item  = value[ITEM_WIDTH-1:0];
        n     = bag_count;
        hits  = 0;
        found = 1'b0;
        case (op)
            OP_ADD: begin
                if (n < STORE_DEPTH) begin
                    bag_items[n] = item;
                    n++;
                    res.success = 1'b1;
                end else begin
                    res.full_res = 1'b1;
                end
            end
            OP_REMOVE: begin
                // Newest match wins; the newest entry fills the hole.
                k = n - 1;
                while (k >= 0 && !found) begin
                    if (bag_items[k] == item) begin
                        bag_items[k] = bag_items[n-1];
                        n--;
                        found = 1'b1;
                    end
                    k--;
                end
                res.success = found;
            end
            OP_COUNT: begin
                for (k = 0; k < n; k++) begin
                    if (bag_items[k] == item)
                        hits++;
                end
                res.occurrences = hits[OUT_CNT_W-1:0];
                res.success     = (hits != 0);
            end
            default: begin
                n           = 0;
                res.success = 1'b1;
            end
        endcase
        bag_count        = n;
        res.current_size = n[OUT_CNT_W-1:0];
        return res;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Check results against the oldest expectation, then record new words.
    always @(posedge aclk) begin
        bag_result_t want;
        bag_result_t pred;
        bit          typed;
        bag_result_t typed_res;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                             $time, m_success, m_occurrences, m_current_size, m_full_res);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    compare_field("success", want.success, m_success);
                    compare_field("occurrences", want.occurrences, m_occurrences);
                    compare_field("current_size", want.current_size, m_current_size);
                    compare_field("full_res", want.full_res, m_full_res);
                end
            end
            if (s_valid && s_ready) begin
                pred      = bag_apply(op_t'(s_operation), s_item_value);
                typed     = typed_flags.pop_front();
                typed_res = typed_results.pop_front();
                expected_results = {expected_results, (typed ? typed_res : pred)};
            end
        end
    end

    // The receiver stalls at random except during the quiet stretch.
    always @(negedge aclk) begin
        if (quiet)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one word, with random gaps first, and wait until it is taken.
    task automatic send_word(input op_t op, input logic [IN_ITEM_W-1:0] value,
                             input bit typed, input bag_result_t typed_res);
        typed_flags   = {typed_flags, typed};
        typed_results = {typed_results, typed_res};
        @(negedge aclk);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_item_value <= value;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic add_row(input op_t op, input logic [IN_ITEM_W-1:0] value, input bit typed,
                           input int ok, input int occ, input int size, input int full);
        stim_row_t row;
        row.op                  = op;
        row.value               = value;
        row.typed               = typed;
        row.result.success      = ok[0];
        row.result.occurrences  = occ[OUT_CNT_W-1:0];
        row.result.current_size = size[OUT_CNT_W-1:0];
        row.result.full_res     = full[0];
        stim_rows = {stim_rows, row};
    endtask

    function automatic op_t pool_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return OP_ADD;
        else if (pick < 65)
            return OP_REMOVE;
        else if (pick < 96)
            return OP_COUNT;
        else
            return OP_CLEAR;
    endfunction

    initial begin
        int          idx;
        int          sent;
        int          kind;
        int          span;
        int          pool_span;
        op_t         op;
        bag_result_t none;

        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_operation  = OP_ADD;
        s_item_value = '0;
        m_ready      = 1'b0;
        quiet        = 1'b0;
        error_count  = 0;
        cycle_count  = 0;
        bag_count    = 0;
        none         = '0;

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (idx = 2; idx < POOL_SIZE; idx++)
            value_pool[idx] = $urandom;

        // Directed rows: extremes, duplicates, misses, empty store and clear.
        add_row(OP_COUNT,  32'h0000_0000, 1, 0, 0, 0, 0);
        add_row(OP_REMOVE, 32'h0000_0000, 1, 0, 0, 0, 0);
        add_row(OP_ADD,    32'h0000_0000, 1, 1, 0, 1, 0);
        add_row(OP_ADD,    32'hFFFF_FFFF, 1, 1, 0, 2, 0);
        add_row(OP_COUNT,  32'hFFFF_FFFF, 1, 1, 1, 2, 0);
        add_row(OP_COUNT,  32'h0000_0000, 1, 1, 1, 2, 0);
        add_row(OP_COUNT,  32'h0000_0001, 1, 0, 0, 2, 0);
        add_row(OP_ADD,    32'hFFFF_FFFF, 1, 1, 0, 3, 0);
        add_row(OP_COUNT,  32'hFFFF_FFFF, 1, 1, 2, 3, 0);
        add_row(OP_REMOVE, 32'hFFFF_FFFF, 1, 1, 0, 2, 0);
        add_row(OP_REMOVE, 32'h1234_5678, 1, 0, 0, 2, 0);
        add_row(OP_ADD,    32'hAAAA_AAAA, 1, 1, 0, 3, 0);
        add_row(OP_ADD,    32'h5555_5555, 1, 1, 0, 4, 0);
        add_row(OP_REMOVE, 32'h0000_0000, 1, 1, 0, 3, 0);
        add_row(OP_COUNT,  32'h5555_5555, 0, 0, 0, 0, 0);
        add_row(OP_COUNT,  32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        add_row(OP_COUNT,  32'h0000_0000, 1, 0, 0, 3, 0);
        add_row(OP_CLEAR,  32'hDEAD_BEEF, 1, 1, 0, 0, 0);
        add_row(OP_COUNT,  32'hAAAA_AAAA, 1, 0, 0, 0, 0);
        add_row(OP_REMOVE, 32'hAAAA_AAAA, 1, 0, 0, 0, 0);
        add_row(OP_ADD,    32'h8000_0000, 1, 1, 0, 1, 0);
        add_row(OP_ADD,    32'h0000_0001, 1, 1, 0, 2, 0);
        add_row(OP_CLEAR,  32'h0000_0000, 1, 1, 0, 0, 0);

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i])
            send_word(stim_rows[i].op, stim_rows[i].value, stim_rows[i].typed,
                      stim_rows[i].result);
        drain_results();

        // Random phases: fill to overflow, pool traffic with many matches, and noise.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                // Run the store past full, mostly with a handful of values.
                pool_span = $urandom_range(0, POOL_SIZE - 1);
                span = STORE_DEPTH + $urandom_range(1, 3);
                for (idx = 0; idx < span; idx++) begin
                    quiet = (sent >= 200 && sent < 320);
                    send_word(OP_ADD, value_pool[$urandom_range(0, pool_span)], 0, none);
                    sent++;
                end
                for (idx = 0; idx < 10; idx++) begin
                    quiet = (sent >= 200 && sent < 320);
                    op = ($urandom_range(0, 1) == 0) ? OP_COUNT : OP_REMOVE;
                    send_word(op, value_pool[$urandom_range(0, pool_span)], 0, none);
                    sent++;
                end
            end else if (kind == 2) begin
                for (idx = 0; idx < 20; idx++) begin
                    quiet = (sent >= 200 && sent < 320);
                    send_word(op_t'($urandom_range(0, 3)), $urandom, 0, none);
                    sent++;
                end
            end else begin
                for (idx = 0; idx < 30; idx++) begin
                    quiet = (sent >= 200 && sent < 320);
                    send_word(pool_op(), value_pool[$urandom_range(0, POOL_SIZE - 1)], 0, none);
                    sent++;
                end
            end
            if ($urandom_range(0, 3) == 0)
                drain_results();
        end
        quiet = 1'b0;

        // Wind down: wait for the last results, then watch for strays.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
